@@ rtl/core/thermistor_adc_to_temperature_core_defines.svh @@
// assertion macros for the thermistor adc to temperature core
// used by the checker; expects aclk and aresetn in scope
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

// same-cycle implication
`define TADC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tadc check failed");

// next-cycle implication
`define TADC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tadc check failed");

`endif

@@ rtl/core/tadc_pkg.sv @@
// shared types and constants of the thermistor adc to temperature core
// no dependencies
package tadc_pkg;

    localparam int CFG_DIV_W   = 20;
    localparam int CFG_NOM_W   = 20;
    localparam int CFG_T0_W    = 19;
    localparam int CFG_BETA_W  = 14;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_DIV_W-1:0]  DIV_RESET  = 20'd10000;
    localparam logic [CFG_NOM_W-1:0]  NOM_RESET  = 20'd10000;
    localparam logic [CFG_T0_W-1:0]   T0_RESET   = 19'd298150;
    localparam logic [CFG_BETA_W-1:0] BETA_RESET = 14'd3950;

    localparam int IN_TDATA_W  = 16;
    localparam int CODE_W      = 12;
    localparam int OUT_TDATA_W = 24;
    localparam int TEMP_W      = 21;

    localparam int MANT_W  = 31;
    localparam int FRAC_W  = 16;
    localparam int LN2_W   = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

    localparam int QUOT2_W = 60;

    localparam logic [TEMP_W-1:0] TEMP_HIGH_MC     = 21'd1000000;
    localparam logic [TEMP_W-1:0] TEMP_LOW_MC      = 21'h1BD502;
    localparam logic [TEMP_W-1:0] KELVIN_OFFSET_MK = 21'd273150;
    localparam logic [QUOT2_W-1:0] TMK_LIMIT       = 60'd1273150;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVIDER = 2'd0,
        REG_NOMINAL = 2'd1,
        REG_T0      = 2'd2,
        REG_BETA    = 2'd3
    } tadc_reg_t;

    typedef enum logic [1:0] {
        KIND_OK  = 2'd0,
        KIND_HOT = 2'd1,
        KIND_LOW = 2'd2
    } tadc_kind_t;

endpackage

@@ rtl/core/tadc_div_cell.sv @@
// one restoring division step, carries the item along the divider row
// depends on nothing
module tadc_div_cell #(
    parameter int DW = 12,
    parameter int QW = 48,
    parameter int SW = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_dq,
    input  logic [DW-1:0] in_dsr,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_dq,
    output logic [DW-1:0] out_dsr,
    output logic [SW-1:0] out_side
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next, dsr_reg;
    logic [QW-1:0] dq_reg, dq_next;
    logic [SW-1:0] side_reg;

    assign trial    = {in_rem, in_dq[QW-1]};
    assign diff     = trial - {1'b0, in_dsr};
    assign ge       = trial >= {1'b0, in_dsr};
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign dq_next  = {in_dq[QW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            dsr_reg  <= in_dsr;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dsr   = dsr_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/core/tadc_norm_cell.sv @@
// one shift step of the leading-one normalizer, two lanes side by side
// depends on nothing
module tadc_norm_cell #(
    parameter int AW = 48,
    parameter int BW = 20,
    parameter int CW = 6,
    parameter int SH = 32,
    parameter int SW = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [AW-1:0] in_a,
    input  logic [CW-1:0] in_ca,
    input  logic [BW-1:0] in_b,
    input  logic [CW-1:0] in_cb,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [AW-1:0] out_a,
    output logic [CW-1:0] out_ca,
    output logic [BW-1:0] out_b,
    output logic [CW-1:0] out_cb,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [AW-1:0] a_reg, a_next;
    logic [CW-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [BW-1:0] b_reg, b_next;
    logic [SW-1:0] side_reg;
    logic          za;

    assign za      = in_a[AW-1 -: SH] == '0;
    assign a_next  = za ? (in_a << SH) : in_a;
    assign ca_next = za ? (in_ca + CW'(SH)) : in_ca;

    generate
        if (SH < BW) begin : g_b_shift
            logic zb;
            assign zb      = in_b[BW-1 -: SH] == '0;
            assign b_next  = zb ? (in_b << SH) : in_b;
            assign cb_next = zb ? (in_cb + CW'(SH)) : in_cb;
        end else begin : g_b_pass
            assign b_next  = in_b;
            assign cb_next = in_cb;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            ca_reg   <= ca_next;
            b_reg    <= b_next;
            cb_reg   <= cb_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_ca    = ca_reg;
    assign out_b     = b_reg;
    assign out_cb    = cb_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/core/tadc_sqr_cell.sv @@
// one squaring step of the log2 fraction, two mantissa lanes
// depends on tadc_pkg
module tadc_sqr_cell
    import tadc_pkg::*;
#(
    parameter int SW = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MANT_W-1:0] in_ma,
    input  logic [MANT_W-1:0] in_mb,
    input  logic [FRAC_W-1:0] in_fa,
    input  logic [FRAC_W-1:0] in_fb,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [MANT_W-1:0] out_ma,
    output logic [MANT_W-1:0] out_mb,
    output logic [FRAC_W-1:0] out_fa,
    output logic [FRAC_W-1:0] out_fb,
    output logic [SW-1:0]     out_side
);

    logic [2*MANT_W-1:0] sq_a, sq_b;
    logic [MANT_W:0]     sa, sb;
    logic                valid_reg;
    logic [MANT_W-1:0]   ma_reg, ma_next, mb_reg, mb_next;
    logic [FRAC_W-1:0]   fa_reg, fb_reg;
    logic [SW-1:0]       side_reg;

    assign sq_a    = (2*MANT_W)'(in_ma) * (2*MANT_W)'(in_ma);
    assign sq_b    = (2*MANT_W)'(in_mb) * (2*MANT_W)'(in_mb);
    assign sa      = sq_a[2*MANT_W-1:MANT_W-1];
    assign sb      = sq_b[2*MANT_W-1:MANT_W-1];
    assign ma_next = sa[MANT_W] ? sa[MANT_W:1] : sa[MANT_W-1:0];
    assign mb_next = sb[MANT_W] ? sb[MANT_W:1] : sb[MANT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            fa_reg   <= {in_fa[FRAC_W-2:0], sa[MANT_W]};
            fb_reg   <= {in_fb[FRAC_W-2:0], sb[MANT_W]};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ma    = ma_reg;
    assign out_mb    = mb_reg;
    assign out_fa    = fa_reg;
    assign out_fb    = fb_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/core/thermistor_adc_to_temperature_core.sv @@
// thermistor adc reading to temperature, b-parameter equation, fully pipelined
// depends on tadc_pkg, tadc_div_cell, tadc_norm_cell, tadc_sqr_cell
//
//  port group | role   | contents
//  s_*        | input  | tdata[11:0] adc_code
//  m_*        | output | tdata[20:0] temp_millicelsius, tuser invalid
//  cfg_*      | config | register write, index 0..3
//
// one item per cycle while no result waits unread; the pipeline holds the two divider rows
// (one quotient bit per cell), the leading-one normalizer and the 16 squaring cells
// aresetn is synchronous; it clears the valid bits and loads the register defaults
// the whole pipeline advances together; it holds only while a result waits unread
module thermistor_adc_to_temperature_core
    import tadc_pkg::*;
#(
    parameter int ADC_WIDTH = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // adc_code
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // temp_millicelsius
    output logic                   m_tuser,   // invalid
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int PROD_W = CFG_DIV_W + ADC_WIDTH;
    localparam int Q1W    = PROD_W + FRAC_W;
    localparam int PW     = $clog2(Q1W);
    localparam int NS     = $clog2(Q1W);
    localparam int SQ_SW  = 2 + 2*PW;
    localparam int L2W    = PW + FRAC_W + 1;
    localparam int MW     = PW + FRAC_W;
    localparam int LQW    = MW + 1;
    localparam int TLW    = CFG_T0_W + 1 + LQW;
    localparam int DENW   = TLW + 2;
    localparam int DW2    = DENW - 1;
    localparam int BT_W   = CFG_BETA_W + CFG_T0_W;
    localparam int B1K_W  = CFG_BETA_W + 10;
    localparam int NUM_W  = BT_W + 10;
    localparam logic [ADC_WIDTH-1:0] FS = '1;

    logic en;

    // configuration registers
    logic [CFG_DIV_W-1:0]  div_reg;
    logic [CFG_NOM_W-1:0]  nom_reg;
    logic [CFG_T0_W-1:0]   t0_reg;
    logic [CFG_BETA_W-1:0] beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg  <= DIV_RESET;
            nom_reg  <= NOM_RESET;
            t0_reg   <= T0_RESET;
            beta_reg <= BETA_RESET;
        end else if (cfg_wr_en) begin
            unique case (tadc_reg_t'(cfg_index))
                REG_DIVIDER: div_reg  <= cfg_wr_data[CFG_DIV_W-1:0];
                REG_NOMINAL: nom_reg  <= cfg_wr_data[CFG_NOM_W-1:0];
                REG_T0:      t0_reg   <= cfg_wr_data[CFG_T0_W-1:0];
                REG_BETA:    beta_reg <= cfg_wr_data[CFG_BETA_W-1:0];
            endcase
        end
    end

    // input stage
    logic [IN_TDATA_W+ADC_WIDTH-1:0] code_ext;
    logic [ADC_WIDTH-1:0]            code;
    logic [PROD_W-1:0]               mul0;
    tadc_kind_t                      kind0;
    logic                            v0_reg;
    tadc_kind_t                      kind0_reg;
    logic [Q1W-1:0]                  dvd0_reg;
    logic [ADC_WIDTH-1:0]            dsr0_reg;

    assign code_ext = {{(IN_TDATA_W+ADC_WIDTH-CODE_W){1'b0}}, s_tdata[CODE_W-1:0]};
    assign code     = code_ext[ADC_WIDTH-1:0];
    assign mul0     = PROD_W'(div_reg) * PROD_W'(code);

    always_comb begin
        priority if (code == '0 || div_reg == '0) begin
            kind0 = KIND_HOT;
        end else if (code == FS || nom_reg == '0) begin
            kind0 = KIND_LOW;
        end else begin
            kind0 = KIND_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind0_reg <= kind0;
            dvd0_reg  <= {mul0, {FRAC_W{1'b0}}};
            dsr0_reg  <= FS - code;
        end
    end

    // resistance divider row
    logic                 d1_v    [0:Q1W];
    logic [ADC_WIDTH-1:0] d1_rem  [0:Q1W];
    logic [Q1W-1:0]       d1_dq   [0:Q1W];
    logic [ADC_WIDTH-1:0] d1_dsr  [0:Q1W];
    logic [1:0]           d1_side [0:Q1W];

    assign d1_v[0]    = v0_reg;
    assign d1_rem[0]  = '0;
    assign d1_dq[0]   = dvd0_reg;
    assign d1_dsr[0]  = dsr0_reg;
    assign d1_side[0] = kind0_reg;

    generate
        for (genvar i = 0; i < Q1W; i++) begin : g_div1
            tadc_div_cell #(.DW(ADC_WIDTH), .QW(Q1W), .SW(2)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (d1_v[i]),
                .in_rem    (d1_rem[i]),
                .in_dq     (d1_dq[i]),
                .in_dsr    (d1_dsr[i]),
                .in_side   (d1_side[i]),
                .out_valid (d1_v[i+1]),
                .out_rem   (d1_rem[i+1]),
                .out_dq    (d1_dq[i+1]),
                .out_dsr   (d1_dsr[i+1]),
                .out_side  (d1_side[i+1])
            );
        end
    endgenerate

    // leading-one normalizer row
    logic                 nm_v    [0:NS];
    logic [Q1W-1:0]       nm_a    [0:NS];
    logic [PW-1:0]        nm_ca   [0:NS];
    logic [CFG_NOM_W-1:0] nm_b    [0:NS];
    logic [PW-1:0]        nm_cb   [0:NS];
    logic [1:0]           nm_side [0:NS];

    assign nm_v[0]    = d1_v[Q1W];
    assign nm_a[0]    = d1_dq[Q1W];
    assign nm_ca[0]   = '0;
    assign nm_b[0]    = nom_reg;
    assign nm_cb[0]   = '0;
    assign nm_side[0] = d1_side[Q1W];

    generate
        for (genvar i = 0; i < NS; i++) begin : g_norm
            tadc_norm_cell #(
                .AW (Q1W),
                .BW (CFG_NOM_W),
                .CW (PW),
                .SH (2**(NS-1-i)),
                .SW (2)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (nm_v[i]),
                .in_a      (nm_a[i]),
                .in_ca     (nm_ca[i]),
                .in_b      (nm_b[i]),
                .in_cb     (nm_cb[i]),
                .in_side   (nm_side[i]),
                .out_valid (nm_v[i+1]),
                .out_a     (nm_a[i+1]),
                .out_ca    (nm_ca[i+1]),
                .out_b     (nm_b[i+1]),
                .out_cb    (nm_cb[i+1]),
                .out_side  (nm_side[i+1])
            );
        end
    endgenerate

    // squaring row for the log2 fractions
    logic              sq_v    [0:FRAC_W];
    logic [MANT_W-1:0] sq_ma   [0:FRAC_W];
    logic [MANT_W-1:0] sq_mb   [0:FRAC_W];
    logic [FRAC_W-1:0] sq_fa   [0:FRAC_W];
    logic [FRAC_W-1:0] sq_fb   [0:FRAC_W];
    logic [SQ_SW-1:0]  sq_side [0:FRAC_W];
    logic [PW-1:0]     p_r, p_0;

    assign p_r = PW'(Q1W - 1) - nm_ca[NS];
    assign p_0 = PW'(CFG_NOM_W - 1 + FRAC_W) - nm_cb[NS];

    assign sq_v[0]    = nm_v[NS];
    assign sq_ma[0]   = nm_a[NS][Q1W-1 -: MANT_W];
    assign sq_mb[0]   = {nm_b[NS], {(MANT_W-CFG_NOM_W){1'b0}}};
    assign sq_fa[0]   = '0;
    assign sq_fb[0]   = '0;
    assign sq_side[0] = {nm_side[NS], p_r, p_0};

    generate
        for (genvar i = 0; i < FRAC_W; i++) begin : g_sqr
            tadc_sqr_cell #(.SW(SQ_SW)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (sq_v[i]),
                .in_ma     (sq_ma[i]),
                .in_mb     (sq_mb[i]),
                .in_fa     (sq_fa[i]),
                .in_fb     (sq_fb[i]),
                .in_side   (sq_side[i]),
                .out_valid (sq_v[i+1]),
                .out_ma    (sq_ma[i+1]),
                .out_mb    (sq_mb[i+1]),
                .out_fa    (sq_fa[i+1]),
                .out_fb    (sq_fb[i+1]),
                .out_side  (sq_side[i+1])
            );
        end
    endgenerate

    // log difference, ln scaling and temperature terms
    logic [SQ_SW-1:0] sqo;
    logic [L2W-1:0]   l2;
    logic             vl_reg, vm_reg, vn_reg, vo_reg, vp_reg, vq_reg;
    logic [1:0]       kl_reg, km_reg, kn_reg, ko_reg, kp_reg;
    logic             negl_reg, negm_reg;
    logic [MW-1:0]    magl_reg;
    logic [MW+LN2_W-1:0] prodm_reg;
    logic [MW+LN2_W:0]   rnd_n;
    logic [LQW-1:0]      q_n;
    logic signed [LQW-1:0] lnq_reg;
    logic [BT_W-1:0]     btn_reg;
    logic [B1K_W-1:0]    b1kn_reg, b1ko_reg;
    logic signed [CFG_T0_W:0] t0s;
    logic signed [TLW-1:0]    t0lnq_o;
    logic signed [TLW-1:0]    t0lnq_reg;
    logic [NUM_W-1:0]         num_reg;
    logic signed [DENW-1:0]   den_p;
    logic signed [DENW-1:0]   den_reg;
    logic [NUM_W+FRAC_W-1:0]  numr_reg;
    logic                     den_pos;
    tadc_kind_t               kq;
    logic [1:0]               kq_reg;
    logic [QUOT2_W-1:0]       dvd2_reg;
    logic [DW2-1:0]           dsr2_reg;

    assign sqo = sq_side[FRAC_W];
    assign l2  = {1'b0, sqo[2*PW-1:PW], sq_fa[FRAC_W]} - {1'b0, sqo[PW-1:0], sq_fb[FRAC_W]};

    assign rnd_n = {1'b0, prodm_reg} + (MW+LN2_W+1)'(1 << (LN2_W - 1));
    assign q_n   = {1'b0, rnd_n[MW+LN2_W-1:LN2_W]};

    assign t0s     = {1'b0, t0_reg};
    assign t0lnq_o = t0s * lnq_reg;

    assign den_p = {{(DENW-TLW){t0lnq_reg[TLW-1]}}, t0lnq_reg}
                 + {{(DENW-B1K_W-FRAC_W){1'b0}}, b1ko_reg, {FRAC_W{1'b0}}};

    assign den_pos = !den_reg[DENW-1] && den_reg != '0;

    always_comb begin
        if (tadc_kind_t'(kp_reg) == KIND_OK && !den_pos) begin
            kq = KIND_HOT;
        end else begin
            kq = tadc_kind_t'(kp_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
            vo_reg <= 1'b0;
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= sq_v[FRAC_W];
            vm_reg <= vl_reg;
            vn_reg <= vm_reg;
            vo_reg <= vn_reg;
            vp_reg <= vo_reg;
            vq_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kl_reg    <= sqo[SQ_SW-1 -: 2];
            negl_reg  <= l2[L2W-1];
            magl_reg  <= l2[L2W-1] ? MW'(-l2) : l2[MW-1:0];
            km_reg    <= kl_reg;
            negm_reg  <= negl_reg;
            prodm_reg <= (MW+LN2_W)'(magl_reg) * (MW+LN2_W)'(LN2_Q30);
            kn_reg    <= km_reg;
            lnq_reg   <= negm_reg ? -q_n : q_n;
            btn_reg   <= BT_W'(beta_reg) * BT_W'(t0_reg);
            b1kn_reg  <= B1K_W'(beta_reg) * B1K_W'(1000);
            ko_reg    <= kn_reg;
            t0lnq_reg <= t0lnq_o;
            num_reg   <= NUM_W'(btn_reg) * NUM_W'(1000);
            b1ko_reg  <= b1kn_reg;
            kp_reg    <= ko_reg;
            den_reg   <= den_p;
            numr_reg  <= {num_reg, {FRAC_W{1'b0}}};
            kq_reg    <= kq;
            dvd2_reg  <= QUOT2_W'(numr_reg) + QUOT2_W'(den_reg[DENW-2:1]);
            dsr2_reg  <= den_pos ? den_reg[DW2-1:0] : DW2'(1);
        end
    end

    // temperature divider row
    logic               d2_v    [0:QUOT2_W];
    logic [DW2-1:0]     d2_rem  [0:QUOT2_W];
    logic [QUOT2_W-1:0] d2_dq   [0:QUOT2_W];
    logic [DW2-1:0]     d2_dsr  [0:QUOT2_W];
    logic [1:0]         d2_side [0:QUOT2_W];

    assign d2_v[0]    = vq_reg;
    assign d2_rem[0]  = '0;
    assign d2_dq[0]   = dvd2_reg;
    assign d2_dsr[0]  = dsr2_reg;
    assign d2_side[0] = kq_reg;

    generate
        for (genvar i = 0; i < QUOT2_W; i++) begin : g_div2
            tadc_div_cell #(.DW(DW2), .QW(QUOT2_W), .SW(2)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (d2_v[i]),
                .in_rem    (d2_rem[i]),
                .in_dq     (d2_dq[i]),
                .in_dsr    (d2_dsr[i]),
                .in_side   (d2_side[i]),
                .out_valid (d2_v[i+1]),
                .out_rem   (d2_rem[i+1]),
                .out_dq    (d2_dq[i+1]),
                .out_dsr   (d2_dsr[i+1]),
                .out_side  (d2_side[i+1])
            );
        end
    endgenerate

    // output register
    logic [QUOT2_W-1:0] tmk;
    logic [TEMP_W-1:0]  temp_sel;
    logic               bad_sel;
    logic               m_tvalid_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic               bad_reg;

    assign tmk = d2_dq[QUOT2_W];

    always_comb begin
        unique case (tadc_kind_t'(d2_side[QUOT2_W]))
            KIND_HOT: begin
                temp_sel = TEMP_HIGH_MC;
                bad_sel  = 1'b1;
            end
            KIND_LOW: begin
                temp_sel = TEMP_LOW_MC;
                bad_sel  = 1'b1;
            end
            default: begin
                if (tmk > TMK_LIMIT) begin
                    temp_sel = TEMP_HIGH_MC;
                    bad_sel  = 1'b1;
                end else begin
                    temp_sel = tmk[TEMP_W-1:0] - KELVIN_OFFSET_MK;
                    bad_sel  = 1'b0;
                end
            end
        endcase
    end

    assign en = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d2_v[QUOT2_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg <= temp_sel;
            bad_reg  <= bad_sel;
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-TEMP_W){1'b0}}, temp_reg};
    assign m_tuser  = bad_reg;

endmodule

@@ rtl/core/tadc_checker.sv @@
// port-level checks of the thermistor adc to temperature core, bound to the top
// depends on thermistor_adc_to_temperature_core_defines.svh
`include "thermistor_adc_to_temperature_core_defines.svh"

module tadc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    logic signed [20:0] temp;

    assign temp = m_tdata[20:0];

    // an invalid item always carries one of the two limits
    `TADC_ASSERT_NOW(a_bad_limit, m_tvalid && m_tuser, temp == 21'sd1000000 || temp == -21'sd273150)

    // a valid item stays inside the temperature range
    `TADC_ASSERT_NOW(a_ok_range, m_tvalid && !m_tuser, temp >= -21'sd273150 && temp <= 21'sd1000000)

    // a held result stalls the input side
    `TADC_ASSERT_NOW(a_stall_in, m_tvalid && !m_tready, !s_tready)

    // a stalled item holds
    `TADC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind thermistor_adc_to_temperature_core tadc_checker u_tadc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/testbench.sv @@
// self-checking bench for thermistor_adc_to_temperature_core: random stream traffic, several
// register settings, every result compared with a fixed-point b-parameter predictor
// depends on tadc_pkg and the core rtl
module testbench
    import tadc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_SCALE = 4095;
    localparam int SETTLE_CYCLES = 140;
    localparam int IDLE_LIMIT = 4000;
    localparam longint unsigned HOT_LIMIT_MK = 1273150;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              invalid;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    tadc_reg_t              cfg_index = REG_DIVIDER;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    longint unsigned divider_ohms, nominal_ohms, nominal_mk, beta_k;

    logic [CODE_W-1:0] pending_codes[$];
    reading_t          expected_readings[$];
    int                mismatches = 0;
    int                idle_cycles = 0;
    int                gap_left = 0;
    int                burst_left = 0;
    int                stall_mode = 0;
    int                mode_left = 0;
    logic              in_taken = 1'b0;

    thermistor_adc_to_temperature_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint log2_q16(longint unsigned x);
        int p;
        longint unsigned m;
        longint frac;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | (longint'(1) << i);
            end
        end
        return longint'(p) * 65536 + frac;
    endfunction

    function automatic reading_t predict_temperature(logic [CODE_W-1:0] code);
        reading_t res;
        longint unsigned r, mag, q, num, tmk, c;
        longint l2, lnq, den;
        c = code;
        if (c == 0 || divider_ohms == 0) begin
            res.temp = TEMP_HIGH_MC;
            res.invalid = 1'b1;
            return res;
        end
        if (c >= FULL_SCALE || nominal_ohms == 0) begin
            res.temp = TEMP_LOW_MC;
            res.invalid = 1'b1;
            return res;
        end
        r = ((divider_ohms * c) << 16) / (FULL_SCALE - c);
        l2 = log2_q16(r) - log2_q16(nominal_ohms << 16);
        mag = longint'(l2 < 0 ? -l2 : l2) * 64'd744261118;
        q = (mag + (64'd1 << 29)) >> 30;
        lnq = (l2 < 0) ? -longint'(q) : longint'(q);
        num = beta_k * nominal_mk * 1000 * 65536;
        den = longint'(beta_k * 1000 * 65536) + longint'(nominal_mk) * lnq;
        if (den <= 0) begin
            res.temp = TEMP_HIGH_MC;
            res.invalid = 1'b1;
            return res;
        end
        tmk = (num + longint'(unsigned'(den)) / 2) / longint'(unsigned'(den));
        if (tmk > HOT_LIMIT_MK) begin
            res.temp = TEMP_HIGH_MC;
            res.invalid = 1'b1;
            return res;
        end
        res.temp = TEMP_W'(longint'(tmk) - 273150);
        res.invalid = 1'b0;
        return res;
    endfunction

    // monitor: predict on input handshakes, check on output handshakes, track registers
    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            in_taken = 1'b0;
            divider_ohms = DIV_RESET;
            nominal_ohms = NOM_RESET;
            nominal_mk = T0_RESET;
            beta_k = BETA_RESET;
        end else begin
            idle_cycles = idle_cycles + 1;
            in_taken = s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(predict_temperature(s_tdata[CODE_W-1:0]));
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                got.temp = m_tdata[TEMP_W-1:0];
                got.invalid = m_tuser;
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: temp %0d invalid %0b",
                                 $signed(got.temp), got.invalid);
                end else begin
                    want = expected_readings.pop_front();
                    if (want != got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: temp exp %0d got %0d, invalid exp %0b got %0b",
                                     $signed(want.temp), $signed(got.temp),
                                     want.invalid, got.invalid);
                    end
                end
            end
            if (cfg_wr_en) begin
                idle_cycles = 0;
                case (cfg_index)
                    REG_DIVIDER: divider_ohms = cfg_wr_data[CFG_DIV_W-1:0];
                    REG_NOMINAL: nominal_ohms = cfg_wr_data[CFG_NOM_W-1:0];
                    REG_T0:      nominal_mk = cfg_wr_data[CFG_T0_W-1:0];
                    REG_BETA:    beta_k = cfg_wr_data[CFG_BETA_W-1:0];
                    default: ;
                endcase
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // driver: bursts of items with random gaps
    always @(negedge aclk) begin
        logic next_valid;
        logic [IN_TDATA_W-1:0] next_data;
        next_valid = s_tvalid;
        next_data = s_tdata;
        if (aresetn) begin
            if (in_taken)
                next_valid = 1'b0;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_codes.size() > 0) begin
                    next_valid = 1'b1;
                    next_data = {{(IN_TDATA_W-CODE_W){1'b0}}, pending_codes.pop_front()};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;
    end

    // receiver: stall pattern switches between modes
    always @(negedge aclk) begin
        logic rdy;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = ($urandom_range(0, 5) == 0);
            default: rdy = ~m_tready;
        endcase
        m_tready <= rdy;
    end

    task automatic write_reg(tadc_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_codes.size() == 0 && !s_tvalid && expected_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                pending_codes.push_back('0);
            else if (pick == 1)
                pending_codes.push_back(CODE_W'(FULL_SCALE));
            else if (pick == 2)
                pending_codes.push_back(CODE_W'($urandom_range(1, 8)));
            else if (pick == 3)
                pending_codes.push_back(CODE_W'($urandom_range(FULL_SCALE - 8, FULL_SCALE - 1)));
            else
                pending_codes.push_back(CODE_W'($urandom_range(0, FULL_SCALE)));
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] settings[9][4];
        settings = '{
            '{20'd10000, 20'd10000, 20'd298150, 20'd3950},
            '{20'd1, 20'd1000000, 20'd200000, 20'd1000},
            '{20'd1000000, 20'd1, 20'd400000, 20'd10000},
            '{20'hFFFFF, 20'hFFFFF, 20'h7FFFF, 20'h3FFF},
            '{20'd0, 20'd4700, 20'd273150, 20'd3435},
            '{20'd4700, 20'd0, 20'd298150, 20'd3950},
            '{20'd100000, 20'd10000, 20'd300000, 20'd0},
            '{20'd22000, 20'd100000, 20'd250000, 20'd4250},
            '{20'd1, 20'd1, 20'd1, 20'd1}
        };
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        pending_codes = '{12'd0, 12'd1, 12'd2, 12'd4093, 12'd4094, 12'd4095, 12'd2047,
                          12'd2048, 12'hAAA, 12'h555, 12'd1000, 12'd3000, 12'd0, 12'd4095};
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_DIVIDER, settings[ph][0]);
            write_reg(REG_NOMINAL, settings[ph][1]);
            write_reg(REG_T0, settings[ph][2]);
            write_reg(REG_BETA, settings[ph][3]);
            if (ph == 1 || ph == 2) begin
                pending_codes.push_back(12'd1);
                pending_codes.push_back(12'd4094);
            end
            load_random(145);
            wait_drained();
        end

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
